// ===== hdl/sha1_hash_peripheral_top_defines.svh =====
// Assertion macros shared by the SHA-1 peripheral checker.
// No dependencies.
`ifndef SHA1_HASH_PERIPHERAL_TOP_DEFINES_SVH
`define SHA1_HASH_PERIPHERAL_TOP_DEFINES_SVH
`define SHP_ASSERT_IMPL(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SHP_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== hdl/shp_pkg.sv =====
// Shared constants and functions for the SHA-1 peripheral.
// No dependencies.
package shp_pkg;
    localparam int unsigned RegCount = 32;
    localparam logic [4:0] REG_CONFIG = 5'd0;
    localparam logic [4:0] REG_RESET = 5'd1;
    localparam logic [4:0] REG_RESULT = 5'd8;
    localparam logic [4:0] REG_DATAIN = 5'd16;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ = 1'b1;
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_RESP,
        ST_INIT,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_HFIN,
        ST_PAD,
        ST_FROUND,
        ST_FADD,
        ST_DIGEST,
        ST_CLEAR,
        ST_WIPE
    } state_t;

    function automatic logic [31:0] bswap(input logic [31:0] v);
        bswap = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        if (t < 7'd20)
            round_k = 32'h5A827999;
        else if (t < 7'd40)
            round_k = 32'h6ED9EBA1;
        else if (t < 7'd60)
            round_k = 32'h8F1BBCDC;
        else
            round_k = 32'hCA62C1D6;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        if (t < 7'd20)
            round_f = (b & c) | (~b & d);
        else if (t < 7'd40 || t >= 7'd60)
            round_f = b ^ c ^ d;
        else
            round_f = (b & c) | (b & d) | (c & d);
    endfunction
endpackage

// ===== hdl/shp_regmem.sv =====
// Register word memory, 32 x 32, one write port and one registered read port.
// Depends on shp_pkg.
module shp_regmem
(
    input  logic        clk,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [4:0]  raddr,
    output logic [31:0] rdata
);
    logic [31:0] mem [shp_pkg::RegCount];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/shp_core.sv =====
// SHA-1 round datapath: working variables, 16-word schedule window, chaining words.
// Depends on shp_pkg.
module shp_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_iv,
    input  logic        clear_h,
    input  logic        start,
    input  logic        shift_in,
    input  logic [31:0] msg_word,
    input  logic        round_en,
    input  logic [6:0]  t,
    input  logic        add_en,
    input  logic [2:0]  hsel,
    output logic [31:0] hword
);
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [16];
    logic [31:0] wt, wnew, tmp;

    assign wnew = {w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]} << 1
                | {31'd0, w_reg[13][31] ^ w_reg[8][31] ^ w_reg[2][31] ^ w_reg[0][31]};
    assign wt = (t < 7'd16) ? w_reg[0] : wnew;
    assign tmp = {a_reg[26:0], a_reg[31:27]} + shp_pkg::round_f(t, b_reg, c_reg, d_reg)
               + e_reg + shp_pkg::round_k(t) + wt;

    always_comb
    begin
        case (hsel)
            3'd0: hword = h_reg[0];
            3'd1: hword = h_reg[1];
            3'd2: hword = h_reg[2];
            3'd3: hword = h_reg[3];
            3'd4: hword = h_reg[4];
            default: hword = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg[0] <= shp_pkg::H0;
            h_reg[1] <= shp_pkg::H1;
            h_reg[2] <= shp_pkg::H2;
            h_reg[3] <= shp_pkg::H3;
            h_reg[4] <= shp_pkg::H4;
        end
        else if (load_iv)
        begin
            h_reg[0] <= shp_pkg::H0;
            h_reg[1] <= shp_pkg::H1;
            h_reg[2] <= shp_pkg::H2;
            h_reg[3] <= shp_pkg::H3;
            h_reg[4] <= shp_pkg::H4;
        end
        else if (clear_h)
        begin
            for (int i = 0; i < 5; i++)
                h_reg[i] <= 32'd0;
        end
        else if (add_en)
        begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (round_en)
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (shift_in || round_en)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= shift_in ? msg_word : wt;
        end
    end
endmodule

// ===== hdl/sha1_hash_peripheral_top.sv =====
// Top level of the SHA-1 register peripheral.
// Depends on shp_pkg, shp_regmem and shp_core.
// After reset the block zeroes all 32 register memory words and takes no request.
// A read passes through accept, memory read and output register, and waits before the
// memory read while an earlier result is untaken. A plain write is done on accept.
// A hash command runs accept, 16 memory reads feeding the schedule window, 80 rounds,
// one add and one config clear; finalize runs 16 pad words, 80 rounds, one add,
// 5 digest writes and one clear, also when issued alone. One request is served at a time;
// a result waits in the output register while the next request is taken.
module sha1_hash_peripheral_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // op[0], reg_index[5:1], write_data[37:6], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // read_data[31:0]
);
    shp_pkg::state_t state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        fin_reg, fin_next;
    logic [63:0] bits_reg, bits_next;
    logic        ov_reg, ov_next;
    logic [31:0] od_reg, od_next;

    logic        op;
    logic [4:0]  idx;
    logic [31:0] wd;
    logic        we;
    logic [4:0]  waddr, raddr;
    logic [31:0] wdata, rdata;
    logic        load_iv, clear_h, start, shift_in, round_en, add_en;
    logic [31:0] msg_word, hword;
    logic [4:0]  idx_reg;

    assign op = s_tdata[0];
    assign idx = s_tdata[5:1];
    assign wd = s_tdata[37:6];
    assign m_tvalid = ov_reg;
    assign m_tdata = od_reg;

    shp_regmem u_mem
    (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    shp_core u_core
    (
        .clk(clk), .rst_n(rst_n), .load_iv(load_iv), .clear_h(clear_h), .start(start),
        .shift_in(shift_in), .msg_word(msg_word), .round_en(round_en), .t(cnt_reg),
        .add_en(add_en), .hsel(cnt_reg[2:0]), .hword(hword)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        fin_next = fin_reg;
        bits_next = bits_reg;
        ov_next = ov_reg;
        od_next = od_reg;
        s_tready = 1'b0;
        we = 1'b0;
        waddr = idx;
        wdata = wd;
        raddr = idx;
        load_iv = 1'b0;
        clear_h = 1'b0;
        start = 1'b0;
        shift_in = 1'b0;
        round_en = 1'b0;
        add_en = 1'b0;
        msg_word = shp_pkg::bswap(rdata);
        if (ov_reg && m_tready)
            ov_next = 1'b0;
        case (state_reg)
            shp_pkg::ST_WIPE:
            begin
                we = 1'b1;
                waddr = cnt_reg[4:0];
                wdata = 32'd0;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd31)
                begin
                    cnt_next = 7'd0;
                    state_next = shp_pkg::ST_IDLE;
                end
            end
            shp_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (op == shp_pkg::OP_READ)
                        state_next = shp_pkg::ST_READ;
                    else
                    begin
                        we = 1'b1;
                        if (idx == shp_pkg::REG_CONFIG && (wd[1] || wd[3]))
                        begin
                            fin_next = wd[3];
                            cnt_next = 7'd0;
                            state_next = wd[1] ? shp_pkg::ST_LOAD : shp_pkg::ST_PAD;
                            if (wd[1])
                                raddr = shp_pkg::REG_DATAIN;
                            start = 1'b1;
                        end
                        else if (idx == shp_pkg::REG_RESET && wd == 32'd1)
                            state_next = shp_pkg::ST_INIT;
                    end
                end
            end
            shp_pkg::ST_READ:
            begin
                raddr = idx_reg;
                if (!ov_reg || m_tready)
                    state_next = shp_pkg::ST_RESP;
            end
            shp_pkg::ST_RESP:
            begin
                ov_next = 1'b1;
                od_next = rdata;
                state_next = shp_pkg::ST_IDLE;
            end
            shp_pkg::ST_INIT:
            begin
                we = 1'b1;
                waddr = cnt_reg[0] ? shp_pkg::REG_RESET : shp_pkg::REG_CONFIG;
                wdata = 32'd0;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg[0])
                begin
                    load_iv = 1'b1;
                    bits_next = 64'd0;
                    cnt_next = 7'd0;
                    state_next = shp_pkg::ST_IDLE;
                end
            end
            shp_pkg::ST_LOAD:
            begin
                raddr = shp_pkg::REG_DATAIN + cnt_reg[4:0] + 5'd1;
                shift_in = 1'b1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd15)
                begin
                    cnt_next = 7'd0;
                    state_next = shp_pkg::ST_ROUND;
                end
            end
            shp_pkg::ST_ROUND, shp_pkg::ST_FROUND:
            begin
                round_en = 1'b1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd79)
                begin
                    cnt_next = 7'd0;
                    state_next = (state_reg == shp_pkg::ST_ROUND) ? shp_pkg::ST_ADD
                                                                 : shp_pkg::ST_FADD;
                end
            end
            shp_pkg::ST_ADD:
            begin
                add_en = 1'b1;
                bits_next = bits_reg + 64'd512;
                state_next = shp_pkg::ST_HFIN;
            end
            shp_pkg::ST_HFIN:
            begin
                we = 1'b1;
                waddr = shp_pkg::REG_CONFIG;
                wdata = 32'd0;
                start = 1'b1;
                state_next = fin_reg ? shp_pkg::ST_PAD : shp_pkg::ST_IDLE;
            end
            shp_pkg::ST_PAD:
            begin
                shift_in = 1'b1;
                case (cnt_reg[3:0])
                    4'd0: msg_word = 32'h80000000;
                    4'd14: msg_word = bits_reg[63:32];
                    4'd15: msg_word = bits_reg[31:0];
                    default: msg_word = 32'd0;
                endcase
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd15)
                begin
                    cnt_next = 7'd0;
                    state_next = shp_pkg::ST_FROUND;
                end
            end
            shp_pkg::ST_FADD:
            begin
                add_en = 1'b1;
                state_next = shp_pkg::ST_DIGEST;
            end
            shp_pkg::ST_DIGEST:
            begin
                we = 1'b1;
                waddr = shp_pkg::REG_RESULT + {2'd0, cnt_reg[2:0]};
                wdata = shp_pkg::bswap(hword);
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd4)
                begin
                    cnt_next = 7'd0;
                    state_next = shp_pkg::ST_CLEAR;
                end
            end
            shp_pkg::ST_CLEAR:
            begin
                we = 1'b1;
                waddr = shp_pkg::REG_CONFIG;
                wdata = 32'd0;
                clear_h = 1'b1;
                bits_next = 64'd0;
                state_next = shp_pkg::ST_IDLE;
            end
            default: state_next = shp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shp_pkg::ST_WIPE;
            cnt_reg <= 7'd0;
            fin_reg <= 1'b0;
            bits_reg <= 64'd0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            fin_reg <= fin_next;
            bits_reg <= bits_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
        if (s_tvalid && s_tready)
            idx_reg <= idx;
    end
endmodule

// ===== hdl/shp_checker.sv =====
// Port-level checker for the SHA-1 peripheral, bound to the top level.
// Depends on sha1_hash_peripheral_top_defines.svh.
`include "sha1_hash_peripheral_top_defines.svh"
module shp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    logic rd_take, wr_take;

    assign rd_take = s_tvalid && s_tready && s_tdata[0];
    assign wr_take = s_tvalid && s_tready && !s_tdata[0];

    `SHP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `SHP_ASSERT_NEXT(a_busy, rd_take, !s_tready, "request taken while busy")
    `SHP_ASSERT_NEXT(a_wr_quiet, wr_take && !m_tvalid, !m_tvalid, "write made result")
    `SHP_ASSERT_IMPL(a_rd_late, $rose(m_tvalid), $past(!s_tready), "result without read")
endmodule

bind sha1_hash_peripheral_top shp_checker u_shp_checker
(
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
